@@ rtl/core/rbhd_pkg.sv @@
`timescale 1ns / 1ps

package rbhd_pkg;

  // Fixed field widths
  localparam int BW_W       = 4;   // bit_width register
  localparam int CFG_DATA_W = 32;  // configuration data bus
  localparam int HDR_W      = 32;  // run header accumulator
  localparam int RUN_W      = 31;  // header >> 1
  localparam int PBL_W      = 35;  // packed bytes left: RUN_W x BW_W
  localparam int HSHIFT_W   = 3;   // header byte counter, saturates at HDR_MAX_BYTES
  localparam logic [HSHIFT_W-1:0] HDR_MAX_BYTES = 3'd5;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Register indexes
  localparam logic REG_BIT_WIDTH   = 1'b0;
  localparam logic REG_VALUE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RLE,
    PH_PACKED
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_RLE,
    CMD_PACKED
  } cmd_kind_t;

  // One classified byte handed from front to back
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [RUN_W-1:0] run;
    logic             end_run;
    logic             last;
  } cmd_t;

  // Configuration write events seen by the back end
  typedef struct packed {
    logic bw_wr;
    logic vc_wr;
  } cfg_evt_t;

endpackage

@@ rtl/core/rbhd_front.sv @@
`timescale 1ns / 1ps

module rbhd_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  input  logic [rbhd_pkg::BW_W-1:0] eff_w,
  input  logic                    q_full,
  output logic                    push,
  output rbhd_pkg::cmd_t          cmd
);

  rbhd_pkg::phase_t                  phase, phase_next;
  logic [rbhd_pkg::HDR_W-1:0]        header_accum, header_accum_next;
  logic [rbhd_pkg::HSHIFT_W-1:0]     header_shift, header_shift_next;
  logic [rbhd_pkg::PBL_W-1:0]        packed_bytes_left, packed_bytes_left_next;

  logic [rbhd_pkg::HDR_W-1:0] part;
  logic [rbhd_pkg::HDR_W-1:0] acc_new;
  logic [rbhd_pkg::PBL_W-1:0] pbl_dec;
  logic [rbhd_pkg::PBL_W-1:0] pbl_new;
  logic                       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  // Place the 7 payload bits of a header byte
  always_comb begin
    case (header_shift)
      3'd0:    part = rbhd_pkg::HDR_W'(data_byte[6:0]);
      3'd1:    part = rbhd_pkg::HDR_W'(data_byte[6:0]) << 7;
      3'd2:    part = rbhd_pkg::HDR_W'(data_byte[6:0]) << 14;
      3'd3:    part = rbhd_pkg::HDR_W'(data_byte[6:0]) << 21;
      3'd4:    part = rbhd_pkg::HDR_W'(data_byte[6:0]) << 28;
      default: part = '0;
    endcase
  end

  assign acc_new = header_accum | part;
  assign pbl_new = rbhd_pkg::PBL_W'(acc_new[rbhd_pkg::HDR_W-1:1]) *
                   rbhd_pkg::PBL_W'(eff_w);
  assign pbl_dec = (packed_bytes_left != '0) ? packed_bytes_left - 1'b1
                                             : packed_bytes_left;

  // Next state of the run parser
  always_comb begin
    phase_next             = phase;
    header_accum_next      = header_accum;
    header_shift_next      = header_shift;
    packed_bytes_left_next = packed_bytes_left;
    if (accept) begin
      case (phase)
        rbhd_pkg::PH_RLE: begin
          header_accum_next = '0;
          phase_next        = rbhd_pkg::PH_HEADER;
        end
        rbhd_pkg::PH_PACKED: begin
          packed_bytes_left_next = pbl_dec;
          if (pbl_dec == '0) phase_next = rbhd_pkg::PH_HEADER;
        end
        default: begin
          if (header_shift < rbhd_pkg::HDR_MAX_BYTES) begin
            header_accum_next = acc_new;
            header_shift_next = header_shift + 1'b1;
          end
          if (!data_byte[7]) begin
            header_shift_next = '0;
            if (acc_new[0]) begin
              header_accum_next      = '0;
              packed_bytes_left_next = pbl_new;
              phase_next = (pbl_new != '0) ? rbhd_pkg::PH_PACKED : rbhd_pkg::PH_HEADER;
            end else begin
              header_accum_next = acc_new;
              phase_next        = rbhd_pkg::PH_RLE;
            end
          end
        end
      endcase
      // Re-arm for the next page
      if (last_byte) begin
        phase_next             = rbhd_pkg::PH_HEADER;
        header_accum_next      = '0;
        header_shift_next      = '0;
        packed_bytes_left_next = '0;
      end
    end
  end

  // Classify the byte for the back end
  always_comb begin
    cmd.data    = data_byte;
    cmd.last    = last_byte;
    cmd.run     = header_accum[rbhd_pkg::HDR_W-1:1];
    cmd.end_run = 1'b0;
    case (phase)
      rbhd_pkg::PH_RLE:    cmd.kind = rbhd_pkg::CMD_RLE;
      rbhd_pkg::PH_PACKED: begin
        cmd.kind    = rbhd_pkg::CMD_PACKED;
        cmd.end_run = (pbl_dec == '0);
      end
      default:             cmd.kind = rbhd_pkg::CMD_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= rbhd_pkg::PH_HEADER;
      header_accum      <= '0;
      header_shift      <= '0;
      packed_bytes_left <= '0;
    end else begin
      phase             <= phase_next;
      header_accum      <= header_accum_next;
      header_shift      <= header_shift_next;
      packed_bytes_left <= packed_bytes_left_next;
    end
  end

endmodule

@@ rtl/core/rbhd_cmd_fifo.sv @@
`timescale 1ns / 1ps

module rbhd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rbhd_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output rbhd_pkg::cmd_t rd_cmd
);

  rbhd_pkg::cmd_t                entries [rbhd_pkg::QUEUE_DEPTH];
  logic [rbhd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rbhd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rbhd_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (count == rbhd_pkg::QCNT_W'(rbhd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // Store the transaction at the tail
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_cmd;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/rbhd_back.sv @@
`timescale 1ns / 1ps

module rbhd_back #(
  parameter int MAX_VALUE_WIDTH = 8,
  parameter int COUNT_BITS      = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  rbhd_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  input  logic [rbhd_pkg::BW_W-1:0]   eff_w,
  input  logic [COUNT_BITS-1:0]       value_count,
  input  rbhd_pkg::cfg_evt_t          cfg_evt,
  input  logic [COUNT_BITS-1:0]       vc_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  value,
  output logic [COUNT_BITS-1:0]       repeat_res,
  output logic                        final_value
);

  localparam int BUF_W  = MAX_VALUE_WIDTH + 7;
  localparam int HELD_W = $clog2(BUF_W + 1);

  logic                  busy;
  logic                  last_r;
  logic                  end_r;
  logic [BUF_W-1:0]      bit_buffer;
  logic [HELD_W-1:0]     bits_held;
  logic [COUNT_BITS-1:0] values_left;

  logic                  src_packed;
  logic                  active;
  logic [BUF_W-1:0]      src_buf;
  logic [HELD_W-1:0]     src_held;
  logic [BUF_W-1:0]      rest_buf;
  logic [HELD_W-1:0]     rest_held;
  logic [7:0]            mask8;
  logic [31:0]           run32;
  logic [31:0]           vl32;
  logic [31:0]           rep32;
  logic                  need;
  logic                  slot_free;
  logic                  step;
  logic                  emit;
  logic [7:0]            res_val;
  logic [COUNT_BITS-1:0] res_rep;
  logic [COUNT_BITS-1:0] vl_dec;
  logic                  byte_done;
  logic                  cur_last;
  logic                  cur_end;

  assign slot_free = !out_valid || out_ready;
  assign active    = busy || q_valid;
  assign src_packed = busy || (q_valid && (q_cmd.kind == rbhd_pkg::CMD_PACKED));

  // Merge a fresh packed byte above the leftover bits
  assign src_buf  = busy ? bit_buffer
                         : (bit_buffer | (BUF_W'(q_cmd.data) << bits_held));
  assign src_held = busy ? bits_held : bits_held + HELD_W'(8);
  assign mask8    = 8'((9'd1 << eff_w) - 9'd1);
  assign rest_buf  = src_buf >> eff_w;
  assign rest_held = src_held - HELD_W'(eff_w);
  assign byte_done = !src_packed || (8'(rest_held) < 8'(eff_w));
  assign cur_last  = busy ? last_r : q_cmd.last;
  assign cur_end   = busy ? end_r : q_cmd.end_run;

  // Clip the run to what is left of the page
  assign run32 = {1'b0, q_cmd.run};
  assign vl32  = 32'(values_left);
  assign rep32 = (run32 < vl32) ? run32 : vl32;

  // Pick the result and decide whether an output slot is needed
  always_comb begin
    if (src_packed) begin
      need    = (values_left != '0);
      res_val = src_buf[7:0] & mask8;
      res_rep = COUNT_BITS'(1);
    end else if (q_cmd.kind == rbhd_pkg::CMD_RLE) begin
      need    = (rep32 != '0);
      res_val = q_cmd.data;
      res_rep = COUNT_BITS'(rep32);
    end else begin
      need    = 1'b0;
      res_val = q_cmd.data;
      res_rep = '0;
    end
  end

  assign step   = active && (!need || slot_free);
  assign emit   = step && need;
  assign q_pop  = step && !busy;
  assign vl_dec = values_left - res_rep;

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value       <= res_val;
      repeat_res  <= res_rep;
      final_value <= (vl_dec == '0);
    end
  end

  // One value per cycle if unstalled; the user keeps config writes to idle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      last_r      <= 1'b0;
      end_r       <= 1'b0;
      bit_buffer  <= '0;
      bits_held   <= '0;
      values_left <= COUNT_BITS'(1);
    end else begin
      if (step && src_packed) begin
        if (!byte_done) begin
          busy   <= 1'b1;
          last_r <= cur_last;
          end_r  <= cur_end;
        end else begin
          busy <= 1'b0;
        end
      end
      // Drop collected bits on a width write or at the end of a run or page
      if (cfg_evt.bw_wr) begin
        bit_buffer <= '0;
        bits_held  <= '0;
      end else if (step && src_packed) begin
        if (byte_done && (cur_end || cur_last)) begin
          bit_buffer <= '0;
          bits_held  <= '0;
        end else begin
          bit_buffer <= rest_buf;
          bits_held  <= rest_held;
        end
      end
      // Reload the count on a write or after the last byte of a page
      if (cfg_evt.vc_wr) begin
        values_left <= vc_data;
      end else if (step && byte_done && cur_last) begin
        values_left <= value_count;
      end else if (emit) begin
        values_left <= vl_dec;
      end
    end
  end

endmodule

@@ rtl/core/rle_bitpack_hybrid_decoder_core.sv @@
`timescale 1ns / 1ps
// Path: with the queue empty, an accepted byte is written into the command queue, and its
// first result is then registered in the output register and held there until taken.
// Throughput: one byte per cycle while results are taken, unless a packed byte completes
// several values (up to eight at width one); it holds the unpacker for each, given out or not.
// A four-entry command queue lets the byte parser run ahead of the unpacker.
// Reset: synchronous, active high; bit_width and value_count return to 1, no clearing pass.

module rle_bitpack_hybrid_decoder_core #(
  parameter int MAX_VALUE_WIDTH = 8,
  parameter int COUNT_BITS      = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          value,
  output logic [COUNT_BITS-1:0]               repeat_res,
  output logic                                final_value,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [rbhd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [rbhd_pkg::BW_W-1:0] bit_width;
  logic [COUNT_BITS-1:0]     value_count;
  logic [rbhd_pkg::BW_W-1:0] eff_w;
  rbhd_pkg::cfg_evt_t        cfg_evt;

  logic                      push;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_valid;
  rbhd_pkg::cmd_t            wr_cmd;
  rbhd_pkg::cmd_t            q_cmd;

  assign cfg_evt.bw_wr = cfg_we && (cfg_index == rbhd_pkg::REG_BIT_WIDTH);
  assign cfg_evt.vc_wr = cfg_we && (cfg_index == rbhd_pkg::REG_VALUE_COUNT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_width   <= rbhd_pkg::BW_W'(1);
      value_count <= COUNT_BITS'(1);
    end else begin
      if (cfg_evt.bw_wr) bit_width <= cfg_data[rbhd_pkg::BW_W-1:0];
      if (cfg_evt.vc_wr) value_count <= cfg_data[COUNT_BITS-1:0];
    end
  end

  // Clamp width: zero acts as one, large values saturate
  always_comb begin
    if (bit_width == '0) begin
      eff_w = rbhd_pkg::BW_W'(1);
    end else if (bit_width > rbhd_pkg::BW_W'(MAX_VALUE_WIDTH)) begin
      eff_w = rbhd_pkg::BW_W'(MAX_VALUE_WIDTH);
    end else begin
      eff_w = bit_width;
    end
  end

  rbhd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .eff_w     (eff_w),
    .q_full    (q_full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  rbhd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_cmd   (wr_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  rbhd_back #(
    .MAX_VALUE_WIDTH (MAX_VALUE_WIDTH),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .eff_w       (eff_w),
    .value_count (value_count),
    .cfg_evt     (cfg_evt),
    .vc_data     (cfg_data[COUNT_BITS-1:0]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .repeat_res  (repeat_res),
    .final_value (final_value)
  );

endmodule

@@ rtl/core/rbhd_checker.sv @@
`timescale 1ns / 1ps

module rbhd_checker #(
  parameter int COUNT_BITS = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [7:0]            value,
  input logic [COUNT_BITS-1:0] repeat_res,
  input logic                  final_value
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) &&
      $stable(repeat_res) && $stable(final_value))
    else $error("result changed while stalled");

  // Every result carries a nonzero repeat count
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_res != '0)
    else $error("result with zero repeat count");

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // Queue space is free right after reset, so input is taken
  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input blocked after reset");

endmodule

bind rle_bitpack_hybrid_decoder_core rbhd_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_rbhd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .value       (value),
  .repeat_res  (repeat_res),
  .final_value (final_value)
);
